// ===== src/dual_channel_moving_average_assert.svh =====
// ----------------------------------------------------------------------------
// Dual channel moving average: assertion macros
// Concurrent check templates for the top level, the file that carries the assertions.
// ----------------------------------------------------------------------------
`ifndef DUAL_CHANNEL_MOVING_AVERAGE_ASSERT_SVH
`define DUAL_CHANNEL_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DCMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dcma_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual channel moving average: shared package
// Field widths, beat payload types and the controller to datapath interface.
// ----------------------------------------------------------------------------
package dcma_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int COUNT_BITS      = 6;
    localparam int WLEN_BITS       = 6;
    localparam int MAX_WINDOW_DEF  = 32;
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(30);

    typedef struct packed {
        logic                   side;
        logic [SAMPLE_BITS-1:0] upper_length;
        logic [SAMPLE_BITS-1:0] lower_length;
    } in_item_t;

    typedef struct packed {
        logic                   out_side;
        logic [SAMPLE_BITS-1:0] avg_upper;
        logic [SAMPLE_BITS-1:0] avg_lower;
        logic [COUNT_BITS-1:0]  sample_count;
    } out_item_t;

    // Commands from the controller, at most one active per cycle.
    typedef struct packed {
        logic load;      // capture the accepted input beat
        logic rd;        // read the oldest pair of the selected side
        logic upd;       // update window state and start the dividers
        logic step;      // one restoring division step
        logic out_load;  // move the quotients into the output register
    } dcma_cmd_t;

    typedef struct packed {
        logic out_free;  // output register can take a new beat this cycle
    } dcma_sts_t;

endpackage

// ===== src/dcma_ctrl.sv =====
// ----------------------------------------------------------------------------
// Dual channel moving average: controller
// Sequences read, update, iterative division and output hand-over.
// ----------------------------------------------------------------------------
module dcma_ctrl
    import dcma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dcma_sts_t sts,
    output dcma_cmd_t cmd
);

    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int SW     = SAMPLE_BITS + CW;
    localparam int STEP_W = $clog2(SW);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                step_last;

    assign step_last = (step_reg == STEP_W'(SW - 1));
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/dcma_datapath.sv =====
// ----------------------------------------------------------------------------
// Dual channel moving average: datapath
// Sample store, per-side window state, two restoring dividers, output register.
// ----------------------------------------------------------------------------
module dcma_datapath
    import dcma_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [WLEN_BITS-1:0] cfg_wr_data,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  dcma_cmd_t            cmd,
    output dcma_sts_t            sts
);

    localparam int PW  = $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int EW  = ((CW > WLEN_BITS) ? CW : WLEN_BITS) + 1;
    localparam int AW  = PW + 1;
    localparam int DEPTH = 2 ** AW;

    // Window length register and window state per side.
    logic [WLEN_BITS-1:0]     window_len_reg;
    logic [CW-1:0]            cnt_reg  [2];
    logic [PW-1:0]            old_reg  [2];
    logic [SW-1:0]            usum_reg [2];
    logic [SW-1:0]            lsum_reg [2];

    // Pair store: upper sample in the high half.
    logic [2*SAMPLE_BITS-1:0] pair_mem [DEPTH];
    logic [2*SAMPLE_BITS-1:0] rd_pair_reg;

    in_item_t                 in_reg;

    // Division lanes share the divisor.
    logic [CW-1:0]            div_reg;
    logic [CW-1:0]            urem_reg, lrem_reg, urem_next, lrem_next;
    logic [SW-1:0]            uquo_reg, lquo_reg, uquo_next, lquo_next;

    logic                     m_valid_reg;
    out_item_t                m_data_reg;

    logic [CW-1:0]            cur_cnt, cnt_next;
    logic [PW-1:0]            cur_old, old_next, slot;
    logic [SW-1:0]            usum_next, lsum_next, udrop, ldrop;
    logic [EW-1:0]            wl_ext, eff_win;
    logic                     drop;
    logic [CW:0]              slot_sum, slot_wrap;

    function automatic logic [CW:0] div_step(input logic [CW-1:0] rem,
                                             input logic          msb,
                                             input logic [CW-1:0] dvs);
        logic [CW:0] trial;
        logic [CW:0] diff;
        trial = {rem, msb};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            div_step = {diff[CW-1:0], 1'b1};
        end else begin
            div_step = {trial[CW-1:0], 1'b0};
        end
    endfunction

    assign cur_cnt = cnt_reg[in_reg.side];
    assign cur_old = old_reg[in_reg.side];

    // Effective window: zero reads as one, anything above the store depth saturates.
    always_comb begin
        wl_ext = EW'(window_len_reg);
        if (window_len_reg == '0) begin
            eff_win = EW'(1);
        end else if (wl_ext > EW'(MAX_WINDOW)) begin
            eff_win = EW'(MAX_WINDOW);
        end else begin
            eff_win = wl_ext;
        end
    end

    assign drop = (EW'(cur_cnt) + EW'(1)) > eff_win;

    always_comb begin
        slot_sum  = (CW + 1)'(cur_old) + (CW + 1)'(cur_cnt);
        slot_wrap = slot_sum - (CW + 1)'(MAX_WINDOW);
        if (slot_sum >= (CW + 1)'(MAX_WINDOW)) begin
            slot = PW'(slot_wrap);
        end else begin
            slot = PW'(slot_sum);
        end
    end

    always_comb begin
        if (drop) begin
            cnt_next = cur_cnt;
            udrop    = SW'(rd_pair_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);
            ldrop    = SW'(rd_pair_reg[SAMPLE_BITS-1:0]);
            if (cur_old == PW'(MAX_WINDOW - 1)) begin
                old_next = '0;
            end else begin
                old_next = cur_old + PW'(1);
            end
        end else begin
            cnt_next = cur_cnt + CW'(1);
            udrop    = '0;
            ldrop    = '0;
            old_next = cur_old;
        end
        usum_next = usum_reg[in_reg.side] - udrop + SW'(in_reg.upper_length);
        lsum_next = lsum_reg[in_reg.side] - ldrop + SW'(in_reg.lower_length);
    end

    always_comb begin
        logic [CW:0] ures;
        logic [CW:0] lres;
        ures      = div_step(urem_reg, uquo_reg[SW-1], div_reg);
        lres      = div_step(lrem_reg, lquo_reg[SW-1], div_reg);
        urem_next = ures[CW:1];
        lrem_next = lres[CW:1];
        uquo_next = {uquo_reg[SW-2:0], ures[0]};
        lquo_next = {lquo_reg[SW-2:0], lres[0]};
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WLEN_RESET;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                cnt_reg[i]  <= '0;
                old_reg[i]  <= '0;
                usum_reg[i] <= '0;
                lsum_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                window_len_reg <= cfg_wr_data;
            end
            if (cmd.upd) begin
                cnt_reg[in_reg.side]  <= cnt_next;
                old_reg[in_reg.side]  <= old_next;
                usum_reg[in_reg.side] <= usum_next;
                lsum_reg[in_reg.side] <= lsum_next;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_reg <= s_data;
        end
        if (cmd.upd) begin
            div_reg  <= cnt_next;
            urem_reg <= '0;
            lrem_reg <= '0;
            uquo_reg <= usum_next;
            lquo_reg <= lsum_next;
        end else if (cmd.step) begin
            urem_reg <= urem_next;
            lrem_reg <= lrem_next;
            uquo_reg <= uquo_next;
            lquo_reg <= lquo_next;
        end
        if (cmd.out_load) begin
            m_data_reg.out_side     <= in_reg.side;
            m_data_reg.avg_upper    <= uquo_reg[SAMPLE_BITS-1:0];
            m_data_reg.avg_lower    <= lquo_reg[SAMPLE_BITS-1:0];
            m_data_reg.sample_count <= COUNT_BITS'(cnt_reg[in_reg.side]);
        end
    end

    // Sample store: one read port, one write port.
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rd_pair_reg <= pair_mem[{in_reg.side, cur_old}];
        end
        if (cmd.upd) begin
            pair_mem[{in_reg.side, slot}] <= {in_reg.upper_length, in_reg.lower_length};
        end
    end

endmodule

// ===== src/dual_channel_moving_average.sv =====
// An accepted beat passes through the read, update and division states, then waits in the
// output state until the output register is free, which then raises m_valid.
// The restoring dividers produce one quotient bit per cycle for both averages together, and
// a new input beat is taken only once the previous result is in the output register.
// Reset (aresetn low, synchronous) empties both windows, zeroes the sums and sets
// window_len to 30; the sample store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Dual channel moving average
// Boxcar averages of upper and lower length samples, kept separately for the
// left and right sides, with a run-time window length.
// ----------------------------------------------------------------------------
`include "dual_channel_moving_average_assert.svh"

module dual_channel_moving_average
    import dcma_pkg::*;
#(
    // Store depth per side; the effective window length saturates at this value.
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [WLEN_BITS-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    // The controller walks each input beat through five phases: capture, a
    // registered read of the side's oldest pair, the window update (which also
    // writes the new pair and loads both dividers), the division steps and the
    // hand-over to the output register. That register sits in front of the result
    // channel, so a finished result may wait there while the next input beat is taken.
    dcma_cmd_t cmd;
    dcma_sts_t sts;

    dcma_ctrl #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the window length register, the per-side counts,
    // pointers and running sums, the pair store and the output register.
    dcma_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cmd         (cmd),
        .sts         (sts)
    );

    // The sequencer never issues two commands in the same cycle.
    `DCMA_ASSERT_SAME(a_cmd_onehot, aclk, aresetn, 1'b1,
        $onehot0({cmd.load, cmd.rd, cmd.upd, cmd.step, cmd.out_load}),
        "more than one datapath command active")

    // Only one beat is in the datapath at a time.
    `DCMA_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input taken again straight after an accepted beat")

    // A result handed to the output register is offered on the next cycle.
    `DCMA_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid,
        "loaded result not presented on the result channel")

    // The output register is only loaded when it is free.
    `DCMA_ASSERT_SAME(a_out_no_overwrite, aclk, aresetn, cmd.out_load,
        !m_valid || m_ready, "pending result overwritten")

endmodule

// ===== dv/dual_channel_moving_average_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual channel moving average: self-checking testbench
// Drives sample beats for both sides through the valid/ready input channel,
// mirrors the per-side boxcar windows in a local predictor, and checks
// every result beat field by field. The run starts with a table of directed
// beats and window settings, then moves on to random beats in phases with
// different window lengths and different idling on either channel.
// ----------------------------------------------------------------------------
module dual_channel_moving_average_test;
    import dcma_pkg::*;

    localparam int MAX_WIN          = MAX_WINDOW_DEF;
    localparam int SUM_BITS         = SAMPLE_BITS + 5;
    localparam int RESET_CYCLES     = 8;
    // Once every owed average is out the block is idle, so a few cycles are
    // enough before a register write. The tail outlasts the time the block spends
    // on one beat, so a stray result would still show.
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 40;
    localparam int QUIET_LIMIT      = 3000;
    localparam int PHASES           = 8;
    localparam int BEATS_PER_PHASE  = 142;

    // One row of the directed table. Where want_given is set, the expected
    // result is typed in and replaces the predictor's figure.
    typedef struct packed {
        logic                 new_window;
        logic [WLEN_BITS-1:0] window_value;
        logic                 want_given;
        in_item_t             beat;
        out_item_t            want;
    } plan_row_t;

    localparam int PLAN_ROWS = 17;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // Out of reset the window length is 30: first beats on each side.
        '{1'b0, 6'd0,  1'b1, '{1'b0, 16'hFFFF, 16'h0000}, '{1'b0, 16'hFFFF, 16'h0000, 6'd1}},
        '{1'b0, 6'd0,  1'b1, '{1'b1, 16'h0000, 16'hFFFF}, '{1'b1, 16'h0000, 16'hFFFF, 6'd1}},
        '{1'b0, 6'd0,  1'b1, '{1'b0, 16'hFFFF, 16'hFFFF}, '{1'b0, 16'hFFFF, 16'h7FFF, 6'd2}},
        '{1'b0, 6'd0,  1'b0, '{1'b1, 16'h8000, 16'h0001}, '0},
        // Window shrunk to one while both sides hold two pairs.
        '{1'b1, 6'd1,  1'b0, '{1'b0, 16'h1234, 16'h5678}, '0},
        '{1'b0, 6'd0,  1'b0, '{1'b0, 16'h0000, 16'h0000}, '0},
        // A length of zero behaves as a length of one.
        '{1'b1, 6'd0,  1'b0, '{1'b1, 16'h0003, 16'h0005}, '0},
        '{1'b0, 6'd0,  1'b0, '{1'b1, 16'hFFFF, 16'hFFFF}, '0},
        // Lengths above the store depth saturate, mixed with lengths at and below it.
        '{1'b1, 6'd63, 1'b0, '{1'b0, 16'h8000, 16'h0001}, '0},
        '{1'b0, 6'd0,  1'b0, '{1'b0, 16'h7FFF, 16'hFFFE}, '0},
        '{1'b1, 6'd32, 1'b0, '{1'b1, 16'hAAAA, 16'h5555}, '0},
        '{1'b0, 6'd0,  1'b0, '{1'b1, 16'h5555, 16'hAAAA}, '0},
        '{1'b1, 6'd2,  1'b0, '{1'b0, 16'h0001, 16'h0002}, '0},
        '{1'b0, 6'd0,  1'b0, '{1'b0, 16'h0003, 16'h0004}, '0},
        '{1'b0, 6'd0,  1'b0, '{1'b0, 16'hFFFF, 16'h0000}, '0},
        '{1'b1, 6'd42, 1'b0, '{1'b1, 16'h0000, 16'h0000}, '0},
        '{1'b1, 6'd21, 1'b0, '{1'b0, 16'hFFFF, 16'hFFFF}, '0}
    };

    // Window length for each random phase; the last phase draws its own.
    localparam logic [WLEN_BITS-1:0] PHASE_WINDOWS [PHASES] =
        '{6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd17, 6'd30, 6'd0};
    // Idling pattern per phase, in percent: none, sender, receiver, both.
    localparam int SENDER_IDLE [4]    = '{0, 55, 0, 33};
    localparam int RECEIVER_STALL [4] = '{0, 0, 55, 33};

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [WLEN_BITS-1:0] cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_item_t             s_data      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_item_t            m_data;

    // Local copy of both windows and of the window length register.
    logic [SAMPLE_BITS-1:0] upper_store [2][MAX_WIN];
    logic [SAMPLE_BITS-1:0] lower_store [2][MAX_WIN];
    int unsigned            fill_count [2];
    int unsigned            oldest_slot [2];
    logic [SUM_BITS-1:0]    upper_sum [2];
    logic [SUM_BITS-1:0]    lower_sum [2];
    logic [WLEN_BITS-1:0]   window_setting = WLEN_RESET;

    // Averages still owed by the block, oldest first.
    out_item_t averages_due [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int failures           = 0;
    int beats_sent         = 0;
    int results_checked    = 0;
    int window_writes      = 0;
    int quiet_cycles       = 0;

    dual_channel_moving_average DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #5 aclk = ~aclk;

    // Appends one pair to its side's window and returns the new averages.
    // When the window is already at (or above) its length, the oldest pair
    // is dropped and the count holds; otherwise the count grows by one.
    function automatic out_item_t average_step(input in_item_t beat);
        int unsigned side_idx;
        int unsigned span;
        int unsigned held;
        int unsigned head;
        int unsigned slot;
        out_item_t   averages;
        side_idx = beat.side;
        span = (window_setting == 0) ? 1 :
               (window_setting > MAX_WIN) ? MAX_WIN : window_setting;
        held = fill_count[side_idx];
        head = oldest_slot[side_idx];
        slot = (head + held) % MAX_WIN;
        if (held + 1 > span) begin
            upper_sum[side_idx] = upper_sum[side_idx] - upper_store[side_idx][head];
            lower_sum[side_idx] = lower_sum[side_idx] - lower_store[side_idx][head];
            head = (head + 1) % MAX_WIN;
        end else begin
            held = held + 1;
        end
        upper_store[side_idx][slot] = beat.upper_length;
        lower_store[side_idx][slot] = beat.lower_length;
        upper_sum[side_idx] = upper_sum[side_idx] + beat.upper_length;
        lower_sum[side_idx] = lower_sum[side_idx] + beat.lower_length;
        fill_count[side_idx]  = held;
        oldest_slot[side_idx] = head;
        averages.out_side     = beat.side;
        averages.avg_upper    = SAMPLE_BITS'(upper_sum[side_idx] / SUM_BITS'(held));
        averages.avg_lower    = SAMPLE_BITS'(lower_sum[side_idx] / SUM_BITS'(held));
        averages.sample_count = COUNT_BITS'(held);
        return averages;
    endfunction

    // Mostly uniform lengths, with the two extremes mixed in now and then.
    function automatic logic [SAMPLE_BITS-1:0] random_length();
        int unsigned pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return SAMPLE_BITS'($urandom_range(0, (1 << SAMPLE_BITS) - 1));
    endfunction

    // Adds one average to the back of the owed list.
    function automatic void owe_average(input out_item_t item);
        averages_due = {averages_due, item};
    endfunction

    // Presents one beat, after any idle cycles the sender pattern calls for,
    // and waits for it to be taken. Valid is left high on return; the caller
    // either presents the next beat or lowers it.
    task automatic send_beat(input in_item_t beat, input logic want_given,
                             input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predicted = average_step(beat);
        owe_average(want_given ? want : predicted);
        beats_sent++;
    endtask

    // Window length writes only happen with the block idle: every owed
    // average has come out and the block has had a few cycles to settle.
    task automatic set_window(input logic [WLEN_BITS-1:0] value);
        s_valid <= 1'b0;
        while (averages_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        window_setting = value;
        window_writes++;
    endtask

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            failures++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    // The receiver stalls at random according to the current pattern.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Every result beat is matched against the oldest owed average.
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (averages_due.size() == 0) begin
                failures++;
                $display("%0t ns: result beat with none expected, actual %h",
                         $time, m_data);
            end else begin
                want = averages_due.pop_front();
                compare_field("out_side", want.out_side, m_data.out_side);
                compare_field("avg_upper", want.avg_upper, m_data.avg_upper);
                compare_field("avg_lower", want.avg_lower, m_data.avg_lower);
                compare_field("sample_count", want.sample_count, m_data.sample_count);
                results_checked++;
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles, %0d averages still owed",
                     $time, quiet_cycles, averages_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int k;
        int r;
        for (int s = 0; s < 2; s++) begin
            fill_count[s]  = 0;
            oldest_slot[s] = 0;
            upper_sum[s]   = '0;
            lower_sum[s]   = '0;
            for (int i = 0; i < MAX_WIN; i++) begin
                upper_store[s][i] = '0;
                lower_store[s][i] = '0;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, no idling on either side.
        for (r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].new_window)
                set_window(PLAN[r].window_value);
            send_beat(PLAN[r].beat, PLAN[r].want_given, PLAN[r].want);
        end

        // Random phases: each one starts with a new window length and cycles
        // through the idling patterns, so gaps fall at every point of the
        // block's division sequence as well as in long unbroken runs.
        for (p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                set_window(WLEN_BITS'($urandom_range(0, 63)));
            else
                set_window(PHASE_WINDOWS[p]);
            sender_idle_pct    = SENDER_IDLE[p % 4];
            receiver_stall_pct = RECEIVER_STALL[p % 4];
            for (k = 0; k < BEATS_PER_PHASE; k++)
                send_beat('{side: 1'($urandom_range(1)),
                            upper_length: random_length(),
                            lower_length: random_length()}, 1'b0, '0);
        end

        s_valid <= 1'b0;
        while (averages_due.size() != 0)
            @(posedge aclk);
        // Any stray result beat would show up within this tail.
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d sample beats on both sides and %0d checked averages,",
                 beats_sent, results_checked);
        $display("over %0d window length settings and four idling patterns.",
                 window_writes);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/dcma_pkg.sv
src/dcma_ctrl.sv
src/dcma_datapath.sv
src/dual_channel_moving_average.sv
dv/dual_channel_moving_average_test.sv
